/* src/owtm_pkg.sv */
// shared types and constants of the thermometer bus master
package owtm_pkg;

  // default width of the microsecond timer
  localparam int TIMER_BITS_DEF = 10;

  // command opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_RESET     = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ_BYTE = 3'd3;
  localparam logic [2:0] OP_READ_BIT  = 3'd4;
  localparam logic [2:0] OP_READ_TEMP = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] CFG_RESET_REC     = 3'd2;
  localparam logic [2:0] CFG_SLOT_START    = 3'd3;
  localparam logic [2:0] CFG_WRITE_SLOT    = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] CFG_READ_REC      = 3'd6;

  // configuration reset values
  localparam logic [9:0] DEF_RESET_LOW     = 10'd480;
  localparam logic [9:0] DEF_PRESENCE_WAIT = 10'd60;
  localparam logic [9:0] DEF_RESET_REC     = 10'd420;
  localparam logic [9:0] DEF_SLOT_START    = 10'd1;
  localparam logic [9:0] DEF_WRITE_SLOT    = 10'd60;
  localparam logic [9:0] DEF_READ_SAMPLE   = 10'd14;
  localparam logic [9:0] DEF_READ_REC      = 10'd45;

  // device command bytes
  localparam logic [7:0] DEV_SKIP_ROM  = 8'hcc;
  localparam logic [7:0] DEV_CONVERT   = 8'h44;
  localparam logic [7:0] DEV_READ_PAD  = 8'hbe;

  // fraction step in ten-thousandths
  localparam logic [13:0] FRAC_STEP = 14'd625;

  // bits in a byte transfer
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // thermometer sequence steps
  localparam logic [3:0] STEP_RESET_A   = 4'd0;
  localparam logic [3:0] STEP_SKIP_A    = 4'd1;
  localparam logic [3:0] STEP_CONVERT   = 4'd2;
  localparam logic [3:0] STEP_POLL      = 4'd3;
  localparam logic [3:0] STEP_RESET_B   = 4'd4;
  localparam logic [3:0] STEP_SKIP_B    = 4'd5;
  localparam logic [3:0] STEP_READ_PAD  = 4'd6;
  localparam logic [3:0] STEP_LOW_BYTE  = 4'd7;
  localparam logic [3:0] STEP_HIGH_BYTE = 4'd8;
  localparam logic [3:0] STEP_RESET_C   = 4'd9;

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // item class decided by the front
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_CMD,
    KIND_NOP
  } kind_t;

  // bus phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_HOLD,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REC
  } phase_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  // width of the packed result beat
  localparam int RES_BITS  = 34;
  localparam int OUT_BYTES = (RES_BITS + 7) / 8;

endpackage

/* src/owtm_front.sv */
// front end: classifies accepted beats and queues them for the engine
module owtm_front import owtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], line_level[8], zero pad
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t                queue_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  item_t                item_in;
  logic                 push;
  logic                 pop;

  // classify the incoming opcode
  always_comb begin
    item_in.opcode     = in_tuser;
    item_in.data_byte  = in_tdata[7:0];
    item_in.line_level = in_tdata[8];
    if (in_tuser == OP_TICK) begin
      item_in.kind = KIND_TICK;
    end else if (in_tuser <= OP_READ_TEMP) begin
      item_in.kind = KIND_CMD;
    end else begin
      item_in.kind = KIND_NOP;
    end
  end

  assign in_tready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (count_r != '0);
  assign q_item    = queue_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // queue control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* src/owtm_back.sv */
// back end: bus timing engine, configuration registers and result register
module owtm_back import owtm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [9:0]           cfg_data,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  item_t                q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_BYTES*8-1:0] out_tdata
);

  localparam logic [TIMER_BITS:0] CNT_MAX = (TIMER_BITS+1)'((1 << TIMER_BITS) - 1);

  // configuration
  logic [9:0] reset_low_r, presence_wait_r, reset_rec_r, slot_start_r;
  logic [9:0] write_slot_r, read_sample_r, read_rec_r;

  // engine state
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] us_cnt_r, us_cnt_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [3:0]            step_r, step_nxt;
  logic [7:0]            temp_low_r, temp_low_nxt;
  logic                  presence_r, presence_nxt;
  logic [2:0]            active_r, active_nxt;

  // result register
  logic                  out_valid_r;
  logic [RES_BITS-1:0]   out_data_r;

  logic                  busy;
  logic                  single_bit;
  logic                  finish;
  logic                  fin;
  logic                  launch;
  logic                  rejected;
  logic [9:0]            len_raw;
  logic [TIMER_BITS:0]   len_eff;
  logic [TIMER_BITS:0]   cnt_inc;
  logic                  drive_low;
  logic [7:0]            read_data;
  logic [6:0]            temp_whole;
  logic [13:0]           temp_frac;
  logic [RES_BITS-1:0]   result;

  assign cfg_ready  = 1'b1;
  assign busy       = (phase_r != PH_IDLE);
  assign single_bit = (active_r == OP_READ_BIT) ||
                      ((active_r == OP_READ_TEMP) && (step_r == STEP_POLL));
  assign q_pop      = q_valid && (!out_valid_r || out_tready);

  // duration of the current phase, zero treated as one, capped at timer range
  always_comb begin
    case (phase_r)
      PH_RST_LOW:            len_raw = reset_low_r;
      PH_RST_WAIT:           len_raw = presence_wait_r;
      PH_RST_REC:            len_raw = reset_rec_r;
      PH_WR_LOW, PH_RD_LOW:  len_raw = slot_start_r;
      PH_WR_HOLD:            len_raw = write_slot_r;
      PH_RD_WAIT:            len_raw = read_sample_r;
      default:               len_raw = read_rec_r;
    endcase
    len_eff = (len_raw == '0) ? (TIMER_BITS+1)'(1) : (TIMER_BITS+1)'(len_raw);
    if (len_eff > CNT_MAX) begin
      len_eff = CNT_MAX;
    end
    cnt_inc = (TIMER_BITS+1)'(us_cnt_r) + 1'b1;
  end

  // next state of the engine
  always_comb begin
    phase_nxt    = phase_r;
    us_cnt_nxt   = us_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    step_nxt     = step_r;
    temp_low_nxt = temp_low_r;
    presence_nxt = presence_r;
    active_nxt   = active_r;
    finish       = 1'b0;
    fin          = 1'b0;
    launch       = 1'b0;
    rejected     = 1'b0;

    case (q_item.kind)
      KIND_TICK: begin
        if (busy) begin
          if (cnt_inc < len_eff) begin
            us_cnt_nxt = cnt_inc[TIMER_BITS-1:0];
          end else begin
            us_cnt_nxt = '0;
            case (phase_r)
              PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
              PH_RST_WAIT: begin
                presence_nxt = q_item.line_level;
                phase_nxt    = PH_RST_REC;
              end
              PH_WR_LOW:   phase_nxt = PH_WR_HOLD;
              PH_WR_HOLD: begin
                shift_nxt   = {1'b0, shift_r[7:1]};
                bit_cnt_nxt = bit_cnt_r + 1'b1;
                if (bit_cnt_nxt >= BYTE_BITS) begin
                  finish = 1'b1;
                end else begin
                  phase_nxt = PH_WR_LOW;
                end
              end
              PH_RD_LOW:   phase_nxt = PH_RD_WAIT;
              PH_RD_WAIT: begin
                if (single_bit) begin
                  shift_nxt = {7'd0, q_item.line_level};
                end else begin
                  shift_nxt = {q_item.line_level, shift_r[7:1]};
                end
                bit_cnt_nxt = bit_cnt_r + 1'b1;
                phase_nxt   = PH_RD_REC;
              end
              PH_RD_REC: begin
                if (single_bit || (bit_cnt_r >= BYTE_BITS)) begin
                  finish = 1'b1;
                end else begin
                  phase_nxt = PH_RD_LOW;
                end
              end
              PH_RST_REC:  finish = 1'b1;
              default:     phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      KIND_CMD: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          active_nxt = q_item.opcode;
          step_nxt   = STEP_RESET_A;
          us_cnt_nxt = '0;
          case (q_item.opcode)
            OP_WRITE: begin
              shift_nxt   = q_item.data_byte;
              bit_cnt_nxt = '0;
              phase_nxt   = PH_WR_LOW;
            end
            OP_READ_BYTE, OP_READ_BIT: begin
              bit_cnt_nxt = '0;
              phase_nxt   = PH_RD_LOW;
            end
            default: phase_nxt = PH_RST_LOW;
          endcase
        end
      end
      default: ;
    endcase

    // end of a basic operation: finish the command, repeat the poll or advance the thermometer sequence
    if (finish) begin
      if (active_r != OP_READ_TEMP) begin
        fin = 1'b1;
      end else if ((step_r == STEP_POLL) && !shift_nxt[0]) begin
        bit_cnt_nxt = '0;
        phase_nxt   = PH_RD_LOW;
      end else begin
        if (step_r == STEP_LOW_BYTE) begin
          temp_low_nxt = shift_nxt;
        end
        if (step_r >= STEP_RESET_C) begin
          fin = 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
          launch   = 1'b1;
        end
      end
    end

    // start the next step of the sequence
    if (launch) begin
      case (step_nxt)
        STEP_SKIP_A, STEP_SKIP_B: begin
          shift_nxt   = DEV_SKIP_ROM;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WR_LOW;
        end
        STEP_CONVERT: begin
          shift_nxt   = DEV_CONVERT;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WR_LOW;
        end
        STEP_READ_PAD: begin
          shift_nxt   = DEV_READ_PAD;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WR_LOW;
        end
        STEP_POLL, STEP_LOW_BYTE, STEP_HIGH_BYTE: begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_RD_LOW;
        end
        default: phase_nxt = PH_RST_LOW;
      endcase
    end

    if (fin) begin
      phase_nxt = PH_IDLE;
    end
  end

  // result fields for this beat
  always_comb begin
    case (phase_nxt)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive_low = 1'b1;
      PH_WR_HOLD:                       drive_low = ~shift_nxt[0];
      default:                          drive_low = 1'b0;
    endcase
    read_data  = '0;
    temp_whole = '0;
    temp_frac  = '0;
    if (fin && ((active_r == OP_READ_BYTE) || (active_r == OP_READ_BIT))) begin
      read_data = shift_nxt;
    end
    if (fin && (active_r == OP_READ_TEMP)) begin
      temp_whole = {shift_nxt[2:0], temp_low_r[7:4]};
      temp_frac  = 14'(temp_low_r[3:0]) * FRAC_STEP;
    end
    result = {temp_frac, temp_whole, read_data, presence_nxt, rejected, fin,
              (phase_nxt != PH_IDLE), drive_low};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= DEF_RESET_LOW;
      presence_wait_r <= DEF_PRESENCE_WAIT;
      reset_rec_r     <= DEF_RESET_REC;
      slot_start_r    <= DEF_SLOT_START;
      write_slot_r    <= DEF_WRITE_SLOT;
      read_sample_r   <= DEF_READ_SAMPLE;
      read_rec_r      <= DEF_READ_REC;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_LOW:     reset_low_r     <= cfg_data;
        CFG_PRESENCE_WAIT: presence_wait_r <= cfg_data;
        CFG_RESET_REC:     reset_rec_r     <= cfg_data;
        CFG_SLOT_START:    slot_start_r    <= cfg_data;
        CFG_WRITE_SLOT:    write_slot_r    <= cfg_data;
        CFG_READ_SAMPLE:   read_sample_r   <= cfg_data;
        CFG_READ_REC:      read_rec_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // engine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      us_cnt_r   <= '0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      step_r     <= '0;
      temp_low_r <= '0;
      presence_r <= 1'b0;
      active_r   <= '0;
    end else if (q_pop) begin
      phase_r    <= phase_nxt;
      us_cnt_r   <= us_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      step_r     <= step_nxt;
      temp_low_r <= temp_low_nxt;
      presence_r <= presence_nxt;
      active_r   <= active_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BYTES*8-RES_BITS){1'b0}}, out_data_r};

endmodule

/* src/one_wire_thermometer_master.sv */
// top level: thermometer bus master, one result beat per input beat
// path: an accepted beat is held in the queue, then popped into the result register
// throughput: one beat per cycle unless result beats stall; one engine step per beat
// the two-entry queue lets input beats flow on while a result beat is held
// reset: synchronous, active low; engine idle, timing registers to defaults
module one_wire_thermometer_master import owtm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,   // data_byte[7:0], line_level[8], zero pad
  input  logic [2:0]             in_tuser,   // opcode[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // drive_low[0], busy_res[1], done_res[2], rejected[3], no_presence[4],
  // read_data[12:5], temp_whole[19:13], temp_fraction[33:20], zero pad
  output logic [OUT_BYTES*8-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [9:0]             cfg_data
);

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // classify and queue
  owtm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // bus engine and result beat
  owtm_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/one_wire_thermometer_master_test.sv */
// testbench for the thermometer bus master: predicts each result beat and checks it field by field
`timescale 1ns / 100ps

module one_wire_thermometer_master_test;
  import owtm_pkg::*;

  // opcodes and register index with no function in the block
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_NONE    = 3'd7;

  localparam int REG_COUNT    = 7;
  localparam int RANDOM_BEATS = 500;
  localparam int ROUND_BEATS  = 150;
  localparam int IDLE_PCT     = 19;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  // result fields, drive_low in the lowest bit
  typedef struct packed {
    logic [13:0] temp_fraction;
    logic [6:0]  temp_whole;
    logic [7:0]  read_data;
    logic        no_presence;
    logic        rejected;
    logic        done;
    logic        busy;
    logic        drive_low;
  } bus_result_t;

  typedef struct {
    logic [2:0] index;
    logic [9:0] value;
  } reg_write_t;

  typedef reg_write_t reg_list_t[$];

  // how the bus answers on tick beats
  typedef enum {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_mode_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata   = '0;
  logic [2:0]             in_tuser   = OP_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index  = CFG_RESET_LOW;
  logic [9:0]             cfg_data   = '0;

  line_mode_t line_mode = LINE_RANDOM;
  bit         steady = 1'b0;
  int         settings_applied = 0;
  int         quiet = 0;

  // timing engine tracker and store of expected result beats
  class master_tracker;
    logic [9:0]  timing [REG_COUNT];
    phase_t      phase;
    logic [9:0]  us_count;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [3:0]  step;
    logic [7:0]  low_byte;
    logic        presence;
    logic [2:0]  command;
    bus_result_t pending_results[$];
    int beats_in, beats_checked, mismatches, commands_done, rejects, temp_reads;

    function new();
      timing[CFG_RESET_LOW]     = DEF_RESET_LOW;
      timing[CFG_PRESENCE_WAIT] = DEF_PRESENCE_WAIT;
      timing[CFG_RESET_REC]     = DEF_RESET_REC;
      timing[CFG_SLOT_START]    = DEF_SLOT_START;
      timing[CFG_WRITE_SLOT]    = DEF_WRITE_SLOT;
      timing[CFG_READ_SAMPLE]   = DEF_READ_SAMPLE;
      timing[CFG_READ_REC]      = DEF_READ_REC;
      phase = PH_IDLE;
      us_count = '0;
      bit_cnt = '0;
      shifter = '0;
      step = STEP_RESET_A;
      low_byte = '0;
      presence = 1'b0;
      command = OP_TICK;
    endfunction

    function void write_reg(logic [2:0] index, logic [9:0] value);
      if (index < REG_COUNT) timing[index] = value;
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function bit polling();
      return phase != PH_IDLE && command == OP_READ_TEMP && step == STEP_POLL;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void enter(phase_t next);
      phase = next;
      us_count = '0;
    endfunction

    // ticks the current phase lasts; a zero setting counts as one
    function logic [10:0] phase_ticks();
      logic [9:0] d;
      case (phase)
        PH_RST_LOW:           d = timing[CFG_RESET_LOW];
        PH_RST_WAIT:          d = timing[CFG_PRESENCE_WAIT];
        PH_RST_REC:           d = timing[CFG_RESET_REC];
        PH_WR_LOW, PH_RD_LOW: d = timing[CFG_SLOT_START];
        PH_WR_HOLD:           d = timing[CFG_WRITE_SLOT];
        PH_RD_WAIT:           d = timing[CFG_READ_SAMPLE];
        default:              d = timing[CFG_READ_REC];
      endcase
      return (d == '0) ? 11'd1 : {1'b0, d};
    endfunction

    function void start_write(logic [7:0] value);
      shifter = value;
      bit_cnt = '0;
      enter(PH_WR_LOW);
    endfunction

    function void start_read();
      bit_cnt = '0;
      enter(PH_RD_LOW);
    endfunction

    function bit single_bit();
      return command == OP_READ_BIT || (command == OP_READ_TEMP && step == STEP_POLL);
    endfunction

    // next transfer of the thermometer sequence
    function void launch_step();
      case (step)
        STEP_SKIP_A, STEP_SKIP_B: start_write(DEV_SKIP_ROM);
        STEP_CONVERT:             start_write(DEV_CONVERT);
        STEP_READ_PAD:            start_write(DEV_READ_PAD);
        STEP_POLL, STEP_LOW_BYTE, STEP_HIGH_BYTE: start_read();
        default:                  enter(PH_RST_LOW);
      endcase
    endfunction

    // a transfer ended; true when the whole command is done
    function bit finish_op();
      if (command != OP_READ_TEMP) return 1'b1;
      if (step == STEP_POLL && !shifter[0]) begin
        start_read();
        return 1'b0;
      end
      if (step == STEP_LOW_BYTE) low_byte = shifter;
      if (step >= STEP_RESET_C) return 1'b1;
      step = step + 4'd1;
      launch_step();
      return 1'b0;
    endfunction

    // advance the engine by one accepted input beat and queue its result
    function void note_beat(logic [2:0] op, logic [7:0] data, logic line);
      bus_result_t r;
      bit fin;
      logic [10:0] cnt;
      r = '0;
      fin = 1'b0;
      beats_in++;
      if (op == OP_TICK) begin
        if (phase != PH_IDLE) begin
          cnt = {1'b0, us_count} + 11'd1;
          if (cnt < phase_ticks()) begin
            us_count = cnt[9:0];
          end else begin
            case (phase)
              PH_RST_LOW: enter(PH_RST_WAIT);
              PH_RST_WAIT: begin
                presence = line;
                enter(PH_RST_REC);
              end
              PH_RST_REC: fin = finish_op();
              PH_WR_LOW: enter(PH_WR_HOLD);
              PH_WR_HOLD: begin
                shifter = shifter >> 1;
                bit_cnt++;
                if (bit_cnt >= BYTE_BITS) fin = finish_op();
                else enter(PH_WR_LOW);
              end
              PH_RD_LOW: enter(PH_RD_WAIT);
              PH_RD_WAIT: begin
                shifter = single_bit() ? {7'b0, line} : {line, shifter[7:1]};
                bit_cnt++;
                enter(PH_RD_REC);
              end
              PH_RD_REC: begin
                if (single_bit() || bit_cnt >= BYTE_BITS) fin = finish_op();
                else enter(PH_RD_LOW);
              end
              default: enter(PH_IDLE);
            endcase
          end
          if (fin) begin
            r.done = 1'b1;
            commands_done++;
            enter(PH_IDLE);
            if (command == OP_READ_BYTE || command == OP_READ_BIT) r.read_data = shifter;
            if (command == OP_READ_TEMP) begin
              temp_reads++;
              r.temp_whole = {shifter[2:0], low_byte[7:4]};
              r.temp_fraction = {10'b0, low_byte[3:0]} * FRAC_STEP;
            end
          end
        end
      end else if (op <= OP_READ_TEMP) begin
        if (phase != PH_IDLE) begin
          r.rejected = 1'b1;
          rejects++;
        end else begin
          command = op;
          step = STEP_RESET_A;
          case (op)
            OP_WRITE:                 start_write(data);
            OP_READ_BYTE, OP_READ_BIT: start_read();
            default:                  enter(PH_RST_LOW);
          endcase
        end
      end
      r.drive_low = (phase == PH_RST_LOW || phase == PH_WR_LOW || phase == PH_RD_LOW) ||
                    (phase == PH_WR_HOLD && !shifter[0]);
      r.busy = phase != PH_IDLE;
      r.no_presence = presence;
      pending_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result beat %0d, %s: expected %0d, got %0d",
                   beats_checked, field, want_v, got_v);
      end
    endfunction

    // compare one result beat with the oldest expectation
    function void check_beat(logic [OUT_BYTES*8-1:0] beat);
      bus_result_t want, got;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("result beat %h with nothing expected", beat);
        return;
      end
      want = pending_results.pop_front();
      got = beat[RES_BITS-1:0];
      beats_checked++;
      compare("drive_low", 32'(want.drive_low), 32'(got.drive_low));
      compare("busy_res", 32'(want.busy), 32'(got.busy));
      compare("done_res", 32'(want.done), 32'(got.done));
      compare("rejected", 32'(want.rejected), 32'(got.rejected));
      compare("no_presence", 32'(want.no_presence), 32'(got.no_presence));
      compare("read_data", 32'(want.read_data), 32'(got.read_data));
      compare("temp_whole", 32'(want.temp_whole), 32'(got.temp_whole));
      compare("temp_fraction", 32'(want.temp_fraction), 32'(got.temp_fraction));
      compare("zero pad", 32'd0, 32'(beat >> RES_BITS));
    endfunction
  endclass

  master_tracker tracker;

  one_wire_thermometer_master i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls at random outside the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  // result checking and watchdog on beats moved
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_beat(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  // bus level answered on a tick beat
  function automatic logic bus_level();
    case (line_mode)
      LINE_HIGH: return 1'b1;
      LINE_LOW:  return tracker.polling() && $urandom_range(3) == 0;
      default:   return $urandom_range(1) != 0;
    endcase
  endfunction

  function automatic logic [2:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return OP_READ_TEMP;
    if (r < 43) return OP_RESET;
    if (r < 61) return OP_WRITE;
    if (r < 79) return OP_READ_BYTE;
    if (r < 97) return OP_READ_BIT;
    return r[0] ? OP_SPARE_LO : OP_SPARE_HI;
  endfunction

  // mostly very short timing so that sequences finish quickly
  function automatic logic [9:0] random_timing();
    case ($urandom_range(15))
      0:       return '0;
      13, 14:  return 10'($urandom_range(6, 3));
      15:      return 10'($urandom_range(24, 7));
      default: return 10'($urandom_range(2, 1));
    endcase
  endfunction

  function automatic reg_list_t all_regs(logic [9:0] value);
    reg_list_t list;
    reg_write_t w;
    for (int i = 0; i < REG_COUNT; i++) begin
      w.index = i[2:0];
      w.value = value;
      list.push_back(w);
    end
    return list;
  endfunction

  // one input beat, sometimes after an idle gap
  task automatic send_beat(logic [2:0] op, logic [7:0] data, logic line);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'b0, line, data};
    do @(posedge clk); while (!in_tready);
    tracker.note_beat(op, data, line);
  endtask

  // start a command and tick the bus until it completes, stray commands mixed in
  task automatic run_command(logic [2:0] op, logic [7:0] data, int stray_pct);
    send_beat(op, data, $urandom_range(1) != 0);
    while (!tracker.idle()) begin
      if ($urandom_range(99) < stray_pct)
        send_beat(3'($urandom_range(OP_SPARE_HI, OP_RESET)), 8'($urandom_range(255)),
                  $urandom_range(1) != 0);
      else
        send_beat(OP_TICK, 8'($urandom_range(255)), bus_level());
    end
  endtask

  // stop sending and wait for every expected result beat
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic load_regs(reg_list_t writes);
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].index;
      cfg_data <= writes[i].value;
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(writes[i].index, writes[i].value);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    reg_list_t regs;
    reg_write_t w;
    int first_random, round_start;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // power-on timing
    run_command(OP_READ_BIT, 8'h00, 0);
    drain();

    // shortest timing, plus a write to the unused index
    regs = all_regs(10'd1);
    w.index = CFG_NONE;
    w.value = 10'h3ff;
    regs.push_back(w);
    load_regs(regs);
    // all-ones scratchpad gives the widest temperature, no device present
    line_mode = LINE_HIGH;
    run_command(OP_READ_TEMP, 8'h00, 0);
    run_command(OP_READ_BYTE, 8'h00, 0);
    run_command(OP_READ_BIT, 8'hff, 0);
    // all-zero scratchpad after several conversion polls
    line_mode = LINE_LOW;
    run_command(OP_READ_TEMP, 8'hff, 0);
    run_command(OP_READ_BYTE, 8'hff, 0);
    run_command(OP_READ_BIT, 8'h00, 0);
    run_command(OP_WRITE, 8'h00, 0);
    run_command(OP_WRITE, 8'hff, 0);
    // ticks while idle and unused opcodes
    send_beat(OP_TICK, 8'hff, 1'b1);
    send_beat(OP_SPARE_LO, 8'h00, 1'b0);
    send_beat(OP_SPARE_HI, 8'hff, 1'b1);
    // commands arriving while busy are turned away
    line_mode = LINE_RANDOM;
    run_command(OP_RESET, 8'h00, 30);
    run_command(OP_READ_TEMP, 8'h00, 10);
    drain();

    // zero settings behave as one tick
    load_regs(all_regs(10'd0));
    run_command(OP_RESET, 8'h00, 0);
    run_command(OP_WRITE, 8'h3c, 0);
    run_command(OP_READ_BYTE, 8'h00, 0);
    drain();

    // long timing on every phase
    load_regs(all_regs(10'd100));
    run_command(OP_READ_BIT, 8'h00, 0);
    drain();

    // random rounds, each with its own timing and bus behavior
    first_random = tracker.beats_in;
    for (int round = 0; tracker.beats_in - first_random < RANDOM_BEATS; round++) begin
      regs.delete();
      for (int i = 0; i < REG_COUNT; i++) begin
        w.index = i[2:0];
        w.value = random_timing();
        regs.push_back(w);
      end
      load_regs(regs);
      steady = (round == 1);
      case ($urandom_range(7))
        0:       line_mode = LINE_HIGH;
        1:       line_mode = LINE_LOW;
        default: line_mode = LINE_RANDOM;
      endcase
      round_start = tracker.beats_in;
      while (tracker.beats_in - round_start < ROUND_BEATS &&
             tracker.beats_in - first_random < RANDOM_BEATS) begin
        if ($urandom_range(9) == 0)
          send_beat(OP_TICK, 8'($urandom_range(255)), $urandom_range(1) != 0);
        run_command(pick_command(), 8'($urandom_range(255)), 4);
      end
      steady = 1'b0;
      drain();
    end

    // let any stray result beat show up
    repeat (4) @(posedge clk);
    $display("%0d input beats over %0d timing settings: %0d commands done, %0d turned away",
             tracker.beats_in, settings_applied, tracker.commands_done, tracker.rejects);
    $display("%0d temperature reads, %0d result beats checked, %0d field mismatches",
             tracker.temp_reads, tracker.beats_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (tracker.pending() != 0)
        $display("%0d expected result beats never arrived", tracker.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
